// ===== rtl/ced_pkg.sv =====
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types, sizes and helpers for the contiguous extent directory.
// ----------------------------------------------------------------------------
package ced_pkg;

	localparam int DIR_DEPTH   = 64;
	localparam int BLOCK_TOTAL = 32;
	localparam int NAME_BYTES  = 8;

	// Directory address width and entry count width
	localparam int DIR_AW  = $clog2(DIR_DEPTH);
	localparam int TOTAL_W = $clog2(DIR_DEPTH + 1);

	// Fixed field widths of the request and response beats
	localparam int KEY_W   = 64;
	localparam int START_W = 5;
	localparam int LEN_W   = 6;
	localparam int IDX_W   = 6;

	// Only the low NAME_BYTES bytes of a key take part
	localparam logic [KEY_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {KEY_W{1'b1}} :
		((KEY_W'(1) << (8 * NAME_BYTES)) - KEY_W'(1));

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_READ = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DEL_RD,
		S_DEL_WR,
		S_RD_WAIT,
		S_FIN
	} state_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [KEY_W-1:0]   name_key;
		logic [START_W-1:0] first_block;
		logic [LEN_W-1:0]   block_count;
		logic [IDX_W-1:0]   entry_index;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [KEY_W-1:0]    entry_name;
		logic [START_W-1:0]  entry_start;
		logic [LEN_W-1:0]    entry_length;
		logic [TOTAL_W-1:0]  file_total;
	} rsp_t;

	// One directory record as kept in the entry memory
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} entry_t;

	// Bits first .. first+count-1 of the block map
	function automatic logic [BLOCK_TOTAL-1:0] span_mask(
		input logic [START_W-1:0] first,
		input logic [LEN_W-1:0]   count
	);
		logic [BLOCK_TOTAL-1:0] m;
		logic [LEN_W:0]         hi;
		m  = '0;
		hi = (LEN_W+1)'(first) + (LEN_W+1)'(count);
		for (int b = 0; b < BLOCK_TOTAL; b++) begin
			m[b] = ((LEN_W+1)'(b) >= (LEN_W+1)'(first)) && ((LEN_W+1)'(b) < hi);
		end
		return m;
	endfunction

endpackage

// ===== rtl/contiguous_extent_directory.sv =====
// ----------------------------------------------------------------------------
// contiguous_extent_directory
// Block-in-use map plus a flat directory of (name, start, length) records.
// Add, delete and read requests each give one response beat.
// ----------------------------------------------------------------------------
// Add and delete search the names, the search reading one record a cycle
//   from the entry memory (one read port, one write port); a read and a
//   refused-when-full add skip the search.
// Requests: one request at a time; a response may wait in its register
//   while the block is idle.
// Reset: map and entry count clear at once, no clearing pass is needed.
module contiguous_extent_directory (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ced_pkg::req_t req_beat,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ced_pkg::rsp_t rsp_beat
);

	// Entry memory, one read port with registered data, one write port
	ced_pkg::entry_t mem [ced_pkg::DIR_DEPTH];
	ced_pkg::entry_t rd_data_q;
	logic                       rd_en;
	logic [ced_pkg::DIR_AW-1:0] rd_addr;
	logic                       wr_en;
	logic [ced_pkg::DIR_AW-1:0] wr_addr;
	ced_pkg::entry_t            wr_data;

	ced_pkg::state_t state_q, state_d;

	logic [ced_pkg::BLOCK_TOTAL-1:0] map_q;
	logic [ced_pkg::TOTAL_W-1:0]     total_q;

	// Request held for the length of its work
	ced_pkg::opcode_t               op_q;
	logic [ced_pkg::KEY_W-1:0]      key_q;
	logic [ced_pkg::START_W-1:0]    first_q;
	logic [ced_pkg::LEN_W-1:0]      count_q;

	// Search walk: issue pointer and the compare stage behind it
	logic [ced_pkg::TOTAL_W-1:0]    scan_q;
	logic                           pend_s1;
	logic [ced_pkg::DIR_AW-1:0]     pidx_s1;
	logic [ced_pkg::DIR_AW-1:0]     hit_q;

	// Result under construction
	ced_pkg::status_t               status_q;
	ced_pkg::entry_t                res_q;

	ced_pkg::rsp_t                  rsp_q;
	logic                           rsp_valid_q;

	logic req_acc;
	logic scan_hit;
	logic scan_miss;
	logic scan_issue;
	logic rsp_free;
	logic range_bad;
	logic [ced_pkg::BLOCK_TOTAL-1:0] add_span;
	logic [ced_pkg::KEY_W-1:0]       req_key;

	assign req_key   = req_beat.name_key & ced_pkg::NAME_MASK;
	assign req_stall = (state_q != ced_pkg::S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

	// Compare the record read last cycle, then decide whether to read another
	assign scan_hit   = pend_s1 && (rd_data_q.key == key_q);
	assign scan_miss  = !pend_s1 && (scan_q == total_q);
	assign scan_issue = !scan_hit && (scan_q < total_q);

	// Range check of an add request
	assign add_span  = ced_pkg::span_mask(first_q, count_q);
	assign range_bad = (count_q == '0) ||
		((ced_pkg::LEN_W+1)'(first_q) + (ced_pkg::LEN_W+1)'(count_q) >
		 (ced_pkg::LEN_W+1)'(ced_pkg::BLOCK_TOTAL)) ||
		((map_q & add_span) != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ced_pkg::S_IDLE: begin
				if (req_acc) begin
					case (req_beat.opcode)
						ced_pkg::OP_ADD: begin
							state_d = (total_q >= ced_pkg::TOTAL_W'(ced_pkg::DIR_DEPTH)) ?
								ced_pkg::S_FIN : ced_pkg::S_SCAN;
						end
						ced_pkg::OP_DEL: state_d = ced_pkg::S_SCAN;
						ced_pkg::OP_READ: begin
							state_d = (ced_pkg::TOTAL_W'(req_beat.entry_index) < total_q) ?
								ced_pkg::S_RD_WAIT : ced_pkg::S_FIN;
						end
						default: state_d = ced_pkg::S_FIN;
					endcase
				end
			end
			ced_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = (op_q == ced_pkg::OP_DEL) ? ced_pkg::S_DEL_RD : ced_pkg::S_FIN;
				end else if (scan_miss) begin
					state_d = ced_pkg::S_FIN;
				end
			end
			ced_pkg::S_DEL_RD:  state_d = ced_pkg::S_DEL_WR;
			ced_pkg::S_DEL_WR:  state_d = ced_pkg::S_FIN;
			ced_pkg::S_RD_WAIT: state_d = ced_pkg::S_FIN;
			ced_pkg::S_FIN: begin
				if (rsp_free) begin
					state_d = ced_pkg::S_IDLE;
				end
			end
			default: state_d = ced_pkg::S_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data_q;
		case (state_q)
			ced_pkg::S_IDLE: begin
				rd_en   = req_acc && (req_beat.opcode == ced_pkg::OP_READ);
				rd_addr = req_beat.entry_index[ced_pkg::DIR_AW-1:0];
			end
			ced_pkg::S_SCAN: begin
				rd_en   = scan_issue;
				rd_addr = scan_q[ced_pkg::DIR_AW-1:0];
				wr_en   = scan_miss && (op_q == ced_pkg::OP_ADD) && !range_bad;
				wr_addr = total_q[ced_pkg::DIR_AW-1:0];
				wr_data = '{key: key_q, start: first_q, len: count_q};
			end
			ced_pkg::S_DEL_RD: begin
				rd_en   = 1'b1;
				rd_addr = ced_pkg::DIR_AW'(total_q - ced_pkg::TOTAL_W'(1));
			end
			ced_pkg::S_DEL_WR: begin
				wr_en   = 1'b1;
				wr_addr = hit_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Entry memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Request capture and result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q     <= req_beat.opcode;
			key_q    <= req_key;
			first_q  <= req_beat.first_block;
			count_q  <= req_beat.block_count;
			res_q    <= '0;
			if (req_beat.opcode == ced_pkg::OP_ADD &&
			    total_q >= ced_pkg::TOTAL_W'(ced_pkg::DIR_DEPTH)) begin
				status_q <= ced_pkg::ST_FULL;
			end else if (req_beat.opcode == ced_pkg::OP_READ &&
			    ced_pkg::TOTAL_W'(req_beat.entry_index) >= total_q) begin
				status_q <= ced_pkg::ST_EMPTY;
			end else begin
				status_q <= ced_pkg::ST_OK;
			end
		end
		if (state_q == ced_pkg::S_SCAN) begin
			if (scan_hit) begin
				hit_q <= pidx_s1;
				if (op_q == ced_pkg::OP_ADD) begin
					status_q <= ced_pkg::ST_DUP;
				end
			end else if (scan_miss) begin
				if (op_q == ced_pkg::OP_DEL) begin
					status_q <= ced_pkg::ST_NOTFOUND;
				end else if (range_bad) begin
					status_q <= ced_pkg::ST_RANGE;
				end
			end
		end
		if (state_q == ced_pkg::S_RD_WAIT) begin
			res_q <= rd_data_q;
		end
		if (state_q == ced_pkg::S_FIN && rsp_free) begin
			rsp_q <= '{status: status_q, entry_name: res_q.key, entry_start: res_q.start,
				entry_length: res_q.len, file_total: total_q};
		end
	end

	// Control state: FSM, search walk, block map, entry count, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ced_pkg::S_IDLE;
			map_q       <= '0;
			total_q     <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			pidx_s1     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_acc) begin
				scan_q  <= '0;
				pend_s1 <= 1'b0;
			end else if (state_q == ced_pkg::S_SCAN) begin
				pend_s1 <= scan_issue;
				pidx_s1 <= scan_q[ced_pkg::DIR_AW-1:0];
				if (scan_issue) begin
					scan_q <= scan_q + ced_pkg::TOTAL_W'(1);
				end
			end
			// Commit an add, or free the range of the record being deleted
			if (state_q == ced_pkg::S_SCAN) begin
				if (scan_miss && op_q == ced_pkg::OP_ADD && !range_bad) begin
					map_q   <= map_q | add_span;
					total_q <= total_q + ced_pkg::TOTAL_W'(1);
				end
				if (scan_hit && op_q == ced_pkg::OP_DEL) begin
					map_q <= map_q & ~ced_pkg::span_mask(rd_data_q.start, rd_data_q.len);
				end
			end
			if (state_q == ced_pkg::S_DEL_WR) begin
				total_q <= total_q - ced_pkg::TOTAL_W'(1);
			end
			// Hold the response beat until taken
			if (state_q == ced_pkg::S_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Entry count never passes the directory depth
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= ced_pkg::TOTAL_W'(ced_pkg::DIR_DEPTH))
		else $error("entry count beyond directory depth");

	// The count moves by at most one per cycle
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != $past(total_q)) |->
		(total_q == $past(total_q) + ced_pkg::TOTAL_W'(1) ||
		 total_q + ced_pkg::TOTAL_W'(1) == $past(total_q)))
		else $error("entry count jumped");

	// Memory writes only at add commit or delete move
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ced_pkg::S_SCAN || state_q == ced_pkg::S_DEL_WR))
		else $error("memory write outside commit");

	// Search reads stay below the entry count
	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && state_q == ced_pkg::S_SCAN) |-> (ced_pkg::TOTAL_W'(rd_addr) < total_q))
		else $error("search read past last entry");

	// A new response beat comes only from the finish state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ced_pkg::S_FIN))
		else $error("response without finished request");

endmodule
